@@ rtl/qbps_pkg.sv @@
// ----------------------------------------------------------------------------
// qbps_pkg: shared types and constants of the quadratic Bezier path smoother
// Coordinate and accumulator widths, controller states, command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package qbps_pkg;

  // Coordinate width of waypoints and samples
  localparam int COORD_W = 16;
  // Largest log2 sample count per segment
  localparam int MAX_LG  = 6;
  localparam logic [2:0] MAX_LG_C = 3'(MAX_LG);
  // Accumulator width: coordinate, N^2 growth and headroom for the differences
  localparam int ACC_W   = COORD_W + 2 * MAX_LG + 3;
  // Sample counter width
  localparam int KW      = MAX_LG;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [KW-1:0]             cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // take a waypoint, update history, latch curve points
    logic setup;  // derive difference terms for a new segment
    logic step;   // emit one sample and advance the curve
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic emit;      // the offered waypoint produces a segment
    logic last;      // current sample is the last of the segment
    logic out_free;  // output register can take a new word
  } stat_t;

  // Sign-extend a coordinate to accumulator width
  function automatic acc_t ext(coord_t v);
    return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

@@ rtl/quadratic_bezier_path_smoother_unit.sv @@
// Segments: a waypoint that closes a segment passes through the setup state, then
//   N sample steps at one word per cycle while the output register can take a
//   word (N = 2^samples_log2, samples_log2 clamped to 6); others only enter history.
// Output stalls hold the sample steps back at the single output register.
// Reset: history empty, samples_log2 = 6, no word pending.
// ----------------------------------------------------------------------------
// quadratic_bezier_path_smoother_unit: top level
// Turns a stream of waypoints into sampled quadratic Bezier segments through
// midpoints, with a controller and a two-axis forward-difference datapath.
// ----------------------------------------------------------------------------
module quadratic_bezier_path_smoother_unit import qbps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  coord_t     in_point_x,
  input  coord_t     in_point_y,
  input  logic       in_path_start,
  output logic       out_valid,
  input  logic       out_stall,
  output coord_t     out_sample_x,
  output coord_t     out_sample_y,
  output logic       out_segment_end,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  qbps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  qbps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_path_start   (in_path_start),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_x    (out_sample_x),
    .out_sample_y    (out_sample_y),
    .out_segment_end (out_segment_end)
  );

endmodule

@@ rtl/qbps_axis.sv @@
// ----------------------------------------------------------------------------
// qbps_axis: one coordinate axis of the smoother datapath
// Keeps the waypoint history of the axis and walks the quadratic curve by
// forward differences of the exact numerator r^2*P0 + 2kr*P1 + k^2*P2.
// ----------------------------------------------------------------------------
module qbps_axis import qbps_pkg::*; (
  input  logic       clk,
  input  cmd_t       cmd,
  input  logic       hist_clr,
  input  coord_t     pt,
  input  logic [2:0] lg,
  output coord_t     sample
);

  coord_t older_r, newer_r;
  coord_t p0_r, p1_r, p2_r;
  acc_t   a_r, b_r, e_r, num_r;

  logic [3:0] sh2;
  logic [3:0] sh1;
  acc_t       bias;
  acc_t       q;
  acc_t       sat_q;

  localparam acc_t ACC_ONE  = acc_t'(1);
  localparam acc_t ACC_ZERO = acc_t'(0);
  localparam acc_t SAT_HI   = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam acc_t SAT_LO   = ~SAT_HI;

  // Midpoint truncated toward zero
  function automatic coord_t half(coord_t a, coord_t b);
    logic signed [COORD_W:0] s;
    logic signed [COORD_W:0] s_adj;
    s     = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    s_adj = s + {{COORD_W{1'b0}}, s[COORD_W]};
    return s_adj[COORD_W:1];
  endfunction

  assign sh2 = {lg, 1'b0};
  assign sh1 = {1'b0, lg} + 4'd1;

  // Hold history, latch curve points, walk the numerator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      older_r <= hist_clr ? '0 : newer_r;
      newer_r <= pt;
      p0_r    <= half(older_r, newer_r);
      p1_r    <= newer_r;
      p2_r    <= half(newer_r, pt);
    end
    if (cmd.setup) begin
      a_r   <= ext(p0_r) - (ext(p1_r) <<< 1) + ext(p2_r);
      e_r   <= ext(p0_r) - (ext(p1_r) <<< 1) + ext(p2_r);
      b_r   <= (ext(p1_r) - ext(p0_r)) <<< sh1;
      num_r <= ext(p0_r) <<< sh2;
    end
    if (cmd.step) begin
      num_r <= num_r + b_r + e_r;
      e_r   <= e_r + (a_r <<< 1);
    end
  end

  // Divide by N^2 toward zero, then clamp to the coordinate range
  always_comb begin
    bias  = (ACC_ONE <<< sh2) - ACC_ONE;
    q     = (num_r + (num_r[ACC_W-1] ? bias : ACC_ZERO)) >>> sh2;
    sat_q = q;
    if (q > SAT_HI) begin
      sat_q = SAT_HI;
    end else if (q < SAT_LO) begin
      sat_q = SAT_LO;
    end
  end

  assign sample = sat_q[COORD_W-1:0];

endmodule

@@ rtl/qbps_dp.sv @@
// ----------------------------------------------------------------------------
// qbps_dp: datapath of the quadratic Bezier path smoother
// Holds the sample count register, the path fill count, the sample counter,
// both coordinate axes and the output word register.
// ----------------------------------------------------------------------------
module qbps_dp import qbps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  coord_t     in_point_x,
  input  coord_t     in_point_y,
  input  logic       in_path_start,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  output logic       out_valid,
  input  logic       out_stall,
  output coord_t     out_sample_x,
  output coord_t     out_sample_y,
  output logic       out_segment_end
);

  logic [2:0] samples_log2_r;
  logic [1:0] seen_r, seen_nxt;
  logic [1:0] seen_eff;
  cnt_t       k_r;
  cnt_t       k_last;
  logic [2:0] lg;
  logic       out_valid_r, out_valid_nxt;
  coord_t     out_x_r, out_y_r;
  logic       out_end_r;
  coord_t     smp_x, smp_y;

  // Clamp the sample count and form the last index
  assign lg     = (samples_log2_r > MAX_LG_C) ? MAX_LG_C : samples_log2_r;
  assign k_last = cnt_t'((KW+1)'(1) << lg) - cnt_t'(1);

  // A path start drops the history
  assign seen_eff = in_path_start ? 2'd0 : seen_r;
  assign seen_nxt = (seen_eff == 2'd2) ? 2'd2 : seen_eff + 2'd1;

  assign stat.emit     = (seen_eff == 2'd2);
  assign stat.last     = (k_r == k_last);
  assign stat.out_free = !out_valid_r || !out_stall;

  // Hold the output word until taken
  assign out_valid_nxt = cmd.step ? 1'b1 : (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_log2_r <= 3'(MAX_LG);
      seen_r         <= 2'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        samples_log2_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        seen_r <= seen_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance the sample counter and load the output word
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      k_r <= '0;
    end else if (cmd.step) begin
      k_r <= k_r + cnt_t'(1);
    end
    if (cmd.step) begin
      out_x_r   <= smp_x;
      out_y_r   <= smp_y;
      out_end_r <= stat.last;
    end
  end

  qbps_axis u_axis_x (
    .clk      (clk),
    .cmd      (cmd),
    .hist_clr (seen_eff == 2'd0),
    .pt       (in_point_x),
    .lg       (lg),
    .sample   (smp_x)
  );

  qbps_axis u_axis_y (
    .clk      (clk),
    .cmd      (cmd),
    .hist_clr (seen_eff == 2'd0),
    .pt       (in_point_y),
    .lg       (lg),
    .sample   (smp_y)
  );

  assign out_valid       = out_valid_r;
  assign out_sample_x    = out_x_r;
  assign out_sample_y    = out_y_r;
  assign out_segment_end = out_end_r;

endmodule

@@ rtl/qbps_ctrl.sv @@
// ----------------------------------------------------------------------------
// qbps_ctrl: controller of the quadratic Bezier path smoother
// Accepts waypoints in idle, then sequences segment setup and one sample
// per cycle while the output register has room.
// ----------------------------------------------------------------------------
module qbps_ctrl import qbps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.emit) begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ test/quadratic_bezier_path_smoother_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_bezier_path_smoother_unit_test: self-checking testbench
// Feeds waypoint words through a table of directed cases and then random
// paths under several sample counts. A local model of the midpoint Bezier
// smoother predicts every sample word, and each output word is checked field
// by field in order. Both sides idle and stall at random, and a long
// receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module quadratic_bezier_path_smoother_unit_test;
  import qbps_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   seg_end;
  } sample_t;

  // One directed waypoint; typed_exp marks a segment whose samples all equal fx, fy
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   start;
    logic   typed_exp;
    coord_t fx;
    coord_t fy;
  } waypoint_row_t;

  localparam coord_t C_MAX        = 32767;
  localparam coord_t C_MIN        = -32768;
  localparam int     NUM_DIRECTED = 24;
  localparam int     NUM_PHASES   = 9;
  localparam int     PHASE_ITEMS  = 53;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 12;
  localparam int     EXP_DEPTH    = 256;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  coord_t     in_point_x = '0;
  coord_t     in_point_y = '0;
  logic       in_path_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  coord_t     out_sample_x;
  coord_t     out_sample_y;
  logic       out_segment_end;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = '0;

  // Predictor state: history of the current path and the sample count setting
  coord_t     hist_old_x = '0;
  coord_t     hist_old_y = '0;
  coord_t     hist_new_x = '0;
  coord_t     hist_new_y = '0;
  int         held_points = 0;
  logic [2:0] lg_setting = 3'd6;

  // Expected sample words, oldest first, in a circular buffer
  sample_t    exp_fifo [EXP_DEPTH];
  int         exp_wr = 0;
  int         exp_rd = 0;
  sample_t    head_sample;
  int         errors = 0;
  int         burst_left = 0;
  logic       hold_off_req = 1'b0;

  logic [2:0] phase_lg [NUM_PHASES] = '{3'd0, 3'd7, 3'd3, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4, 3'd0};

  waypoint_row_t dir_rows [NUM_DIRECTED] = '{
    // no path start after reset: points accumulate from empty history
    '{100, -200, 1'b0, 1'b0, 0, 0},
    '{300, 400, 1'b0, 1'b0, 0, 0},
    '{-500, 600, 1'b0, 1'b0, 0, 0},
    '{-7, 9, 1'b0, 1'b0, 0, 0},
    // top of range everywhere
    '{C_MAX, C_MAX, 1'b1, 1'b0, 0, 0},
    '{C_MAX, C_MAX, 1'b0, 1'b0, 0, 0},
    '{C_MAX, C_MAX, 1'b0, 1'b1, C_MAX, C_MAX},
    // bottom of range everywhere
    '{C_MIN, C_MIN, 1'b1, 1'b0, 0, 0},
    '{C_MIN, C_MIN, 1'b0, 1'b0, 0, 0},
    '{C_MIN, C_MIN, 1'b0, 1'b1, C_MIN, C_MIN},
    '{C_MAX, C_MIN, 1'b0, 1'b0, 0, 0},
    '{C_MIN, C_MAX, 1'b0, 1'b0, 0, 0},
    '{0, 0, 1'b1, 1'b0, 0, 0},
    '{0, 0, 1'b0, 1'b0, 0, 0},
    '{0, 0, 1'b0, 1'b1, 0, 0},
    // small negatives exercise truncation toward zero
    '{-1, 1, 1'b0, 1'b0, 0, 0},
    '{1, -1, 1'b0, 1'b0, 0, 0},
    '{-3, 3, 1'b0, 1'b0, 0, 0},
    // swing between the extremes
    '{C_MIN, C_MAX, 1'b1, 1'b0, 0, 0},
    '{C_MAX, C_MIN, 1'b0, 1'b0, 0, 0},
    '{C_MIN, C_MAX, 1'b0, 1'b0, 0, 0},
    // paths too short to emit
    '{12345, -12345, 1'b1, 1'b0, 0, 0},
    '{-1000, 2000, 1'b1, 1'b0, 0, 0},
    '{5, 5, 1'b0, 1'b0, 0, 0}
  };

  quadratic_bezier_path_smoother_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_path_start   (in_path_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_x    (out_sample_x),
    .out_sample_y    (out_sample_y),
    .out_segment_end (out_segment_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // Integer half, truncated toward zero
  function automatic longint midpoint(input longint a, input longint b);
    return (a + b) / 2;
  endfunction

  // Exact Bezier sample along one axis, truncated toward zero and saturated
  function automatic coord_t bezier_axis(input longint p0, input longint p1,
                                         input longint p2, input int k, input int n);
    longint r;
    longint num;
    longint q;
    r   = n - k;
    num = r * r * p0 + 2 * k * r * p1 + longint'(k) * k * p2;
    q   = num / (longint'(n) * n);
    if (q > C_MAX) q = C_MAX;
    if (q < C_MIN) q = C_MIN;
    return coord_t'(q);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return coord_t'(int'($urandom_range(0, 400)) - 200);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Work out the sample words caused by one accepted waypoint, then advance history
  task automatic predict_segment(input coord_t px, input coord_t py, input logic s,
                                 input logic typed_exp, input coord_t fx, input coord_t fy);
    int      lg;
    int      n;
    longint  ax;
    longint  ay;
    longint  bx;
    longint  by;
    sample_t smp;
    if (s) held_points = 0;
    if (held_points >= 2) begin
      lg = (lg_setting > MAX_LG_C) ? MAX_LG : int'(lg_setting);
      n  = 1 << lg;
      ax = midpoint(hist_old_x, hist_new_x);
      ay = midpoint(hist_old_y, hist_new_y);
      bx = midpoint(hist_new_x, px);
      by = midpoint(hist_new_y, py);
      for (int k = 0; k < n; k++) begin
        smp.x       = typed_exp ? fx : bezier_axis(ax, hist_new_x, bx, k, n);
        smp.y       = typed_exp ? fy : bezier_axis(ay, hist_new_y, by, k, n);
        smp.seg_end = (k == n - 1);
        exp_fifo[exp_wr % EXP_DEPTH] = smp;
        exp_wr++;
      end
    end
    if (held_points == 0) begin
      hist_old_x = '0;
      hist_old_y = '0;
    end else begin
      hist_old_x = hist_new_x;
      hist_old_y = hist_new_y;
    end
    hist_new_x = px;
    hist_new_y = py;
    if (held_points < 2) held_points++;
  endtask

  // Offer one waypoint word in bursts with random gaps; predict once accepted
  task automatic send_point(input coord_t x, input coord_t y, input logic s,
                            input logic typed_exp, input coord_t fx, input coord_t fy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_path_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_segment(x, y, s, typed_exp, fx, fy);
  endtask

  // Drain the block, then write the sample count register
  task automatic write_samples_log2(input logic [2:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    lg_setting = v;
    burst_left = 0;
  endtask

  // Mostly well-formed paths with random points; some short or broken ones
  task automatic run_random_paths(input int items);
    int   sent;
    int   path_len;
    logic s;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) path_len = $urandom_range(1, 2);
      else path_len = $urandom_range(3, 12);
      for (int i = 0; i < path_len && sent < items; i++) begin
        s = (i == 0);
        if ($urandom_range(0, 19) == 0) s = 1'($urandom_range(0, 1));
        send_point(rand_coord(), rand_coord(), s, 1'b0, '0, '0);
        sent++;
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    phase_lg[NUM_PHASES-1] = 3'($urandom_range(0, 7));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].start,
                 dir_rows[i].typed_exp, dir_rows[i].fx, dir_rows[i].fy);
    end
    foreach (phase_lg[p]) begin
      write_samples_log2(phase_lg[p]);
      // hold the receiver off while long segments keep coming
      if (phase_lg[p] == 3'd7) hold_off_req = 1'b1;
      run_random_paths(PHASE_ITEMS);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: stall in changing modes, or hold off for a long stretch on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (tick % 4 != 0);
        endcase
      end
    end
  end

  // Check each accepted sample word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        $display("%0t unexpected sample word: x=%0d y=%0d end=%b",
                 $time, out_sample_x, out_sample_y, out_segment_end);
        errors++;
      end else begin
        head_sample = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_sample_x !== head_sample.x) begin
          $display("%0t sample_x mismatch: expected %0d actual %0d",
                   $time, head_sample.x, out_sample_x);
          errors++;
        end
        if (out_sample_y !== head_sample.y) begin
          $display("%0t sample_y mismatch: expected %0d actual %0d",
                   $time, head_sample.y, out_sample_y);
          errors++;
        end
        if (out_segment_end !== head_sample.seg_end) begin
          $display("%0t segment_end mismatch: expected %b actual %b",
                   $time, head_sample.seg_end, out_segment_end);
          errors++;
        end
      end
    end
  end

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
